// ===== rtl/core/ats_pkg.sv =====
package ats_pkg;

    localparam int MAX_CITIES = 64;
    localparam int CITY_BITS = $clog2(MAX_CITIES);
    localparam int COUNT_BITS = 7;
    localparam int DIST_BITS = 16;
    localparam int LEN_BITS = 22;
    localparam int TEMP_BITS = 48;
    localparam int FRAC_BITS = 32;
    localparam int QUOT_BITS = 21;
    localparam int ITER_BITS = 5;
    localparam int CFG_BITS = 48;
    localparam int CFG_INDEX_BITS = 2;

    localparam logic [LEN_BITS-1:0] LEN_MAX = {LEN_BITS{1'b1}};
    localparam logic [COUNT_BITS-1:0] RESET_COUNT = 7'd64;
    localparam logic [TEMP_BITS-1:0] RESET_TEMP = 48'd42949672960000;
    localparam logic [FRAC_BITS-1:0] RESET_RATE = 32'd4294537800;
    localparam logic [TEMP_BITS-1:0] RESET_FINAL = 48'd42950;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_START = 2'd1,
        OP_STEP  = 2'd2,
        OP_READ  = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_BAD_POS  = 2'd1,
        STAT_FINISHED = 2'd2
    } stat_t;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_CITY_COUNT = 2'd0,
        REG_INIT_TEMP  = 2'd1,
        REG_COOL_RATE  = 2'd2,
        REG_FINAL_TEMP = 2'd3
    } reg_index_t;

    typedef enum logic [1:0] {
        TSEL_P1,
        TSEL_P2,
        TSEL_IDX
    } tsel_t;

    typedef enum logic [1:0] {
        WD_RD,
        WD_T1,
        WD_T2
    } wsel_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_DISPATCH,
        S_RD_WAIT,
        S_SW_RD1,
        S_SW_RD2,
        S_SW_WR1,
        S_SW_WR2,
        S_LEN_RD,
        S_LEN_CITY,
        S_LEN_ACC,
        S_DECIDE,
        S_DIV,
        S_EXP,
        S_JUDGE,
        S_UNDO1,
        S_UNDO2,
        S_COOL1,
        S_COOL2,
        S_DONE
    } state_t;

    typedef struct packed {
        logic  latch_in;
        logic  dist_wr;
        logic  start_init;
        tsel_t tour_rsel;
        logic  tour_wr;
        logic  tour_wr_p2;
        wsel_t tour_wsel;
        logic  cap_t1;
        logic  cap_t2;
        logic  cap_city;
        logic  len_clear;
        logic  len_city;
        logic  len_acc;
        logic  len_inc;
        logic  len_to_cur;
        logic  take_swap;
        logic  set_status;
        stat_t status_code;
        logic  div_init;
        logic  div_step;
        logic  exp_init;
        logic  exp_step;
        logic  cool1;
        logic  cool2;
        logic  out_load;
    } ats_cmd_t;

    typedef struct packed {
        op_t  op;
        logic finished_now;
        logic pos_bad;
        logic idx_zero;
        logic idx_at_end;
        logic nl_less;
        logic cur_pos;
        logic reject_big;
        logic iter_last;
        logic p_gt_u;
    } ats_status_t;

    // floor(2^32 * exp(-2^(i-16))) for each bit i of the Q16 exponent argument.
    function automatic logic [FRAC_BITS-1:0] exp_factor(input logic [ITER_BITS-1:0] i);
        logic [FRAC_BITS-1:0] f;
        case (i)
            5'd0:    f = 32'd4294901760;
            5'd1:    f = 32'd4294836225;
            5'd2:    f = 32'd4294705159;
            5'd3:    f = 32'd4294443039;
            5'd4:    f = 32'd4293918847;
            5'd5:    f = 32'd4292870655;
            5'd6:    f = 32'd4290775039;
            5'd7:    f = 32'd4286586874;
            5'd8:    f = 32'd4278222805;
            5'd9:    f = 32'd4261543595;
            5'd10:   f = 32'd4228379999;
            5'd11:   f = 32'd4162825044;
            5'd12:   f = 32'd4034748382;
            5'd13:   f = 32'd3790295335;
            5'd14:   f = 32'd3344923893;
            5'd15:   f = 32'd2605029347;
            5'd16:   f = 32'd1580030168;
            5'd17:   f = 32'd581260615;
            5'd18:   f = 32'd78665070;
            5'd19:   f = 32'd1440801;
            5'd20:   f = 32'd483;
            default: f = '0;
        endcase
        return f;
    endfunction

endpackage

// ===== rtl/core/ats_ctrl.sv =====
module ats_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    output logic                 out_valid,
    input  logic                 out_stall,
    input  ats_pkg::ats_status_t sts,
    output ats_pkg::ats_cmd_t    cmd
);

    ats_pkg::state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ats_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall = (state_reg != ats_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        cmd.tour_rsel = ats_pkg::TSEL_IDX;
        cmd.tour_wsel = ats_pkg::WD_RD;
        cmd.status_code = ats_pkg::STAT_OK;
        out_valid_next = out_valid_reg && out_stall;
        case (state_reg)
            ats_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.latch_in = 1'b1;
                    state_next = ats_pkg::S_DISPATCH;
                end
            end
            ats_pkg::S_DISPATCH:
            begin
                case (sts.op)
                    ats_pkg::OP_LOAD:
                    begin
                        cmd.dist_wr = 1'b1;
                        state_next = ats_pkg::S_DONE;
                    end
                    ats_pkg::OP_START:
                    begin
                        cmd.start_init = 1'b1;
                        cmd.len_clear = 1'b1;
                        state_next = ats_pkg::S_LEN_RD;
                    end
                    ats_pkg::OP_STEP:
                    begin
                        if (sts.finished_now)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_code = ats_pkg::STAT_FINISHED;
                            state_next = ats_pkg::S_DONE;
                        end
                        else if (sts.pos_bad)
                        begin
                            cmd.set_status = 1'b1;
                            cmd.status_code = ats_pkg::STAT_BAD_POS;
                            state_next = ats_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = ats_pkg::S_SW_RD1;
                        end
                    end
                    default:
                    begin
                        cmd.tour_rsel = ats_pkg::TSEL_P1;
                        state_next = ats_pkg::S_RD_WAIT;
                    end
                endcase
            end
            ats_pkg::S_RD_WAIT:
            begin
                cmd.cap_city = 1'b1;
                state_next = ats_pkg::S_DONE;
            end
            ats_pkg::S_SW_RD1:
            begin
                cmd.tour_rsel = ats_pkg::TSEL_P1;
                state_next = ats_pkg::S_SW_RD2;
            end
            ats_pkg::S_SW_RD2:
            begin
                cmd.tour_rsel = ats_pkg::TSEL_P2;
                cmd.cap_t1 = 1'b1;
                state_next = ats_pkg::S_SW_WR1;
            end
            ats_pkg::S_SW_WR1:
            begin
                cmd.cap_t2 = 1'b1;
                cmd.tour_wr = 1'b1;
                cmd.tour_wsel = ats_pkg::WD_RD;
                state_next = ats_pkg::S_SW_WR2;
            end
            ats_pkg::S_SW_WR2:
            begin
                cmd.tour_wr = 1'b1;
                cmd.tour_wr_p2 = 1'b1;
                cmd.tour_wsel = ats_pkg::WD_T1;
                cmd.len_clear = 1'b1;
                state_next = ats_pkg::S_LEN_RD;
            end
            ats_pkg::S_LEN_RD:
            begin
                state_next = ats_pkg::S_LEN_CITY;
            end
            ats_pkg::S_LEN_CITY:
            begin
                cmd.len_city = 1'b1;
                if (sts.idx_zero)
                begin
                    cmd.len_inc = 1'b1;
                    state_next = ats_pkg::S_LEN_RD;
                end
                else
                begin
                    state_next = ats_pkg::S_LEN_ACC;
                end
            end
            ats_pkg::S_LEN_ACC:
            begin
                cmd.len_acc = 1'b1;
                if (!sts.idx_at_end)
                begin
                    cmd.len_inc = 1'b1;
                    state_next = ats_pkg::S_LEN_RD;
                end
                else if (sts.op == ats_pkg::OP_START)
                begin
                    state_next = ats_pkg::S_DONE;
                end
                else
                begin
                    state_next = ats_pkg::S_DECIDE;
                end
            end
            ats_pkg::S_DECIDE:
            begin
                if (sts.nl_less)
                begin
                    cmd.take_swap = 1'b1;
                    state_next = ats_pkg::S_COOL1;
                end
                else if (sts.cur_pos && !sts.reject_big)
                begin
                    cmd.div_init = 1'b1;
                    state_next = ats_pkg::S_DIV;
                end
                else
                begin
                    state_next = ats_pkg::S_UNDO1;
                end
            end
            ats_pkg::S_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.iter_last)
                begin
                    cmd.exp_init = 1'b1;
                    state_next = ats_pkg::S_EXP;
                end
            end
            ats_pkg::S_EXP:
            begin
                cmd.exp_step = 1'b1;
                if (sts.iter_last)
                begin
                    state_next = ats_pkg::S_JUDGE;
                end
            end
            ats_pkg::S_JUDGE:
            begin
                if (sts.p_gt_u)
                begin
                    cmd.take_swap = 1'b1;
                    state_next = ats_pkg::S_COOL1;
                end
                else
                begin
                    state_next = ats_pkg::S_UNDO1;
                end
            end
            ats_pkg::S_UNDO1:
            begin
                cmd.tour_wr = 1'b1;
                cmd.tour_wsel = ats_pkg::WD_T1;
                state_next = ats_pkg::S_UNDO2;
            end
            ats_pkg::S_UNDO2:
            begin
                cmd.tour_wr = 1'b1;
                cmd.tour_wr_p2 = 1'b1;
                cmd.tour_wsel = ats_pkg::WD_T2;
                state_next = ats_pkg::S_COOL1;
            end
            ats_pkg::S_COOL1:
            begin
                cmd.cool1 = 1'b1;
                state_next = ats_pkg::S_COOL2;
            end
            ats_pkg::S_COOL2:
            begin
                cmd.cool2 = 1'b1;
                state_next = ats_pkg::S_DONE;
            end
            ats_pkg::S_DONE:
            begin
                // The output register is reused only once its last transfer is done.
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.out_load = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ats_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ats_pkg::S_IDLE;
            end
        endcase
        // A start item stores the summed length as the current length.
        cmd.len_to_cur = (state_reg == ats_pkg::S_LEN_ACC) && sts.idx_at_end
                         && (sts.op == ats_pkg::OP_START);
    end

endmodule

// ===== rtl/core/ats_datapath.sv =====
module ats_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  ats_pkg::ats_cmd_t                    cmd,
    output ats_pkg::ats_status_t                 sts,
    input  logic                                 cfg_write,
    input  logic [ats_pkg::CFG_INDEX_BITS-1:0]   cfg_index,
    input  logic [ats_pkg::CFG_BITS-1:0]         cfg_data,
    input  logic [1:0]                           operation,
    input  logic [5:0]                           from_city,
    input  logic [5:0]                           to_city,
    input  logic [15:0]                          distance_value,
    input  logic [5:0]                           first_position,
    input  logic [5:0]                           second_position,
    input  logic [31:0]                          uniform_fraction,
    output logic [1:0]                           status,
    output logic                                 accepted,
    output logic [21:0]                          tour_length,
    output logic [47:0]                          current_temperature,
    output logic [5:0]                           tour_city,
    output logic                                 finished
);

    localparam int CB = ats_pkg::CITY_BITS;
    localparam int NB = ats_pkg::COUNT_BITS;
    localparam int DB = ats_pkg::DIST_BITS;
    localparam int LB = ats_pkg::LEN_BITS;
    localparam int TB = ats_pkg::TEMP_BITS;
    localparam int FB = ats_pkg::FRAC_BITS;
    localparam int QB = ats_pkg::QUOT_BITS;
    localparam int IB = ats_pkg::ITER_BITS;

    // Configuration registers
    logic [NB-1:0] city_count_reg;
    logic [TB-1:0] init_temp_reg;
    logic [FB-1:0] cool_rate_reg;
    logic [TB-1:0] final_temp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            city_count_reg <= ats_pkg::RESET_COUNT;
            init_temp_reg <= ats_pkg::RESET_TEMP;
            cool_rate_reg <= ats_pkg::RESET_RATE;
            final_temp_reg <= ats_pkg::RESET_FINAL;
        end
        else if (cfg_write)
        begin
            case (ats_pkg::reg_index_t'(cfg_index))
                ats_pkg::REG_CITY_COUNT: city_count_reg <= cfg_data[NB-1:0];
                ats_pkg::REG_INIT_TEMP:  init_temp_reg <= cfg_data[TB-1:0];
                ats_pkg::REG_COOL_RATE:  cool_rate_reg <= cfg_data[FB-1:0];
                ats_pkg::REG_FINAL_TEMP: final_temp_reg <= cfg_data[TB-1:0];
                default: ;
            endcase
        end
    end

    logic [NB-1:0] n_use;
    always_comb
    begin
        if (city_count_reg < NB'(2))
            n_use = NB'(2);
        else if (city_count_reg > NB'(ats_pkg::MAX_CITIES))
            n_use = NB'(ats_pkg::MAX_CITIES);
        else
            n_use = city_count_reg;
    end

    // Latched input item
    ats_pkg::op_t op_reg;
    logic [CB-1:0] from_reg, to_reg, p1_reg, p2_reg;
    logic [DB-1:0] dv_reg;
    logic [FB-1:0] u_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            op_reg <= ats_pkg::op_t'(operation);
            from_reg <= from_city;
            to_reg <= to_city;
            dv_reg <= distance_value;
            p1_reg <= first_position;
            p2_reg <= second_position;
            u_reg <= uniform_fraction;
        end
    end

    // Tour store: an entry without its valid bit holds the identity order.
    logic [CB-1:0] tour_mem [ats_pkg::MAX_CITIES];
    logic [ats_pkg::MAX_CITIES-1:0] tour_valid_reg;
    logic [CB-1:0] tour_q_reg, tour_a_reg;
    logic tour_v_reg;
    logic [CB-1:0] tour_rd, tour_ra, tour_wa, tour_wd;
    logic [NB-1:0] idx_reg;
    logic [CB-1:0] t1_reg, t2_reg;

    always_comb
    begin
        case (cmd.tour_rsel)
            ats_pkg::TSEL_P1: tour_ra = p1_reg;
            ats_pkg::TSEL_P2: tour_ra = p2_reg;
            default:          tour_ra = (idx_reg == n_use) ? '0 : idx_reg[CB-1:0];
        endcase
        case (cmd.tour_wsel)
            ats_pkg::WD_T1: tour_wd = t1_reg;
            ats_pkg::WD_T2: tour_wd = t2_reg;
            default:        tour_wd = tour_rd;
        endcase
        tour_wa = cmd.tour_wr_p2 ? p2_reg : p1_reg;
    end

    assign tour_rd = tour_v_reg ? tour_q_reg : tour_a_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.tour_wr)
            tour_mem[tour_wa] <= tour_wd;
        tour_q_reg <= tour_mem[tour_ra];
        tour_v_reg <= tour_valid_reg[tour_ra];
        tour_a_reg <= tour_ra;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tour_valid_reg <= '0;
        else if (cmd.start_init)
            tour_valid_reg <= '0;
        else if (cmd.tour_wr)
            tour_valid_reg[tour_wa] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.cap_t1)
            t1_reg <= tour_rd;
        if (cmd.cap_t2)
            t2_reg <= tour_rd;
    end

    // Distance matrix
    logic [DB-1:0] dist_mem [ats_pkg::MAX_CITIES * ats_pkg::MAX_CITIES];
    logic [DB-1:0] dist_q_reg;
    logic [CB-1:0] prev_reg;

    always_ff @(posedge clk)
    begin
        if (cmd.dist_wr)
            dist_mem[{from_reg, to_reg}] <= dv_reg;
        dist_q_reg <= dist_mem[{prev_reg, tour_rd}];
    end

    // Tour length walk
    logic [LB-1:0] sum_reg, cur_reg;
    logic [LB:0] sum_ext;
    logic [LB-1:0] sum_sat;

    assign sum_ext = {1'b0, sum_reg} + (LB+1)'(dist_q_reg);
    assign sum_sat = sum_ext[LB] ? ats_pkg::LEN_MAX : sum_ext[LB-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.len_city)
            prev_reg <= tour_rd;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
            idx_reg <= '0;
        end
        else
        begin
            if (cmd.len_clear)
            begin
                sum_reg <= '0;
                idx_reg <= '0;
            end
            else
            begin
                if (cmd.len_acc)
                    sum_reg <= sum_sat;
                if (cmd.len_inc)
                    idx_reg <= idx_reg + NB'(1);
            end
        end
    end

    // Annealing state
    logic [TB-1:0] temp_reg;
    logic [2*FB-1:0] cool_lo_reg;
    logic [TB:0] cool_sum;
    logic accepted_reg;
    ats_pkg::stat_t status_reg;
    logic [CB-1:0] city_reg;

    assign cool_sum = (TB+1)'(TB'(temp_reg[TB-1:FB]) * TB'(cool_rate_reg))
                      + (TB+1)'(cool_lo_reg[2*FB-1:FB]);

    always_ff @(posedge clk)
    begin
        if (cmd.cool1)
            cool_lo_reg <= temp_reg[FB-1:0] * cool_rate_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg <= ats_pkg::RESET_TEMP;
            cur_reg <= '0;
        end
        else
        begin
            if (cmd.start_init)
                temp_reg <= init_temp_reg;
            else if (cmd.cool2)
                temp_reg <= cool_sum[TB-1:0];
            // The closing edge is added in the same cycle that a start stores the length.
            if (cmd.len_to_cur)
                cur_reg <= sum_sat;
            else if (cmd.take_swap)
                cur_reg <= sum_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.latch_in)
        begin
            accepted_reg <= 1'b0;
            status_reg <= ats_pkg::STAT_OK;
            city_reg <= '0;
        end
        else
        begin
            if (cmd.take_swap)
                accepted_reg <= 1'b1;
            if (cmd.set_status)
                status_reg <= cmd.status_code;
            if (cmd.cap_city)
                city_reg <= tour_rd;
        end
    end

    // Exponent argument by restoring division, then the product of exp factors.
    logic [LB-1:0] delta;
    logic [TB:0] rem_reg;
    logic [TB+1:0] rem_dbl;
    logic [QB-1:0] q_reg;
    logic [FB:0] p_reg;
    logic [2*FB:0] p_prod;
    logic [IB-1:0] iter_reg;
    logic [LB+FB:0] big_lhs, big_rhs;

    assign delta = sum_reg - cur_reg;
    assign rem_dbl = {rem_reg, 1'b0};
    assign p_prod = p_reg * ats_pkg::exp_factor(iter_reg);
    assign big_lhs = (LB+FB+1)'({delta, {FB{1'b0}}});
    assign big_rhs = (LB+FB+1)'({temp_reg, 4'b0}) + (LB+FB+1)'({temp_reg, 2'b0})
                     + (LB+FB+1)'({temp_reg, 1'b0}) + (LB+FB+1)'(temp_reg);

    always_ff @(posedge clk)
    begin
        if (cmd.div_init)
        begin
            rem_reg <= (TB+1)'({delta, {(TB-QB){1'b0}}});
            q_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            if (rem_dbl >= (TB+2)'(temp_reg))
            begin
                rem_reg <= (TB+1)'(rem_dbl - (TB+2)'(temp_reg));
                q_reg <= {q_reg[QB-2:0], 1'b1};
            end
            else
            begin
                rem_reg <= rem_dbl[TB:0];
                q_reg <= {q_reg[QB-2:0], 1'b0};
            end
        end
        else if (cmd.exp_step)
        begin
            if (q_reg[0])
                p_reg <= p_prod[2*FB:FB];
            q_reg <= q_reg >> 1;
        end
        if (cmd.exp_init)
            p_reg <= (FB+1)'(1) << FB;
        if (cmd.div_init || cmd.exp_init)
            iter_reg <= '0;
        else if (cmd.div_step || cmd.exp_step)
            iter_reg <= iter_reg + IB'(1);
    end

    always_comb
    begin
        sts.op = op_reg;
        sts.finished_now = (temp_reg <= final_temp_reg);
        sts.pos_bad = (p1_reg == '0) || (NB'(p1_reg) >= n_use)
                      || (p2_reg == '0) || (NB'(p2_reg) >= n_use);
        sts.idx_zero = (idx_reg == '0);
        sts.idx_at_end = (idx_reg == n_use);
        sts.nl_less = (sum_reg < cur_reg);
        sts.cur_pos = (cur_reg != '0);
        sts.reject_big = (big_lhs >= big_rhs);
        sts.iter_last = (iter_reg == IB'(QB - 1));
        sts.p_gt_u = (p_reg > {1'b0, u_reg});
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            status <= status_reg;
            accepted <= accepted_reg;
            tour_length <= cur_reg;
            current_temperature <= temp_reg;
            tour_city <= city_reg;
            finished <= (temp_reg <= final_temp_reg);
        end
    end

endmodule

// ===== rtl/core/annealing_tour_swap_step_core.sv =====
// Simulated-annealing tour engine with two-position swaps.
// Input channel (in_valid/in_stall) carries one item per transfer: load a
// distance entry, start a run, do one anneal step, or read a tour entry.
// Output channel (out_valid/out_stall) returns exactly one result per item.
// Configuration is written through cfg_write/cfg_index/cfg_data; the user must
// write it only while idle, which the block itself does not enforce. Items are
// handled one at a time; in_stall is low only when the sequencer is idle. A
// load goes from dispatch to the output register; a read passes a wait state
// for the tour memory. Start and step walk the tour once through the tour and
// distance memories, each with one read port. A step whose swap needs the
// exponential test adds a restoring division and a product of exp factors; a
// rejected swap is written back to its old order before the temperature is cooled.
// A result waits in the output register while out_stall is high; the next
// item is already accepted and runs, holding at its end until that transfer.
// Reset gives the identity tour, length zero, the reset temperature and
// the reset register values; the distance matrix is undefined until loaded.
module annealing_tour_swap_step_core (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_write,
    input  logic [ats_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [ats_pkg::CFG_BITS-1:0]       cfg_data,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic [1:0]                         operation,
    input  logic [5:0]                         from_city,
    input  logic [5:0]                         to_city,
    input  logic [15:0]                        distance_value,
    input  logic [5:0]                         first_position,
    input  logic [5:0]                         second_position,
    input  logic [31:0]                        uniform_fraction,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic [1:0]                         status,
    output logic                               accepted,
    output logic [21:0]                        tour_length,
    output logic [47:0]                        current_temperature,
    output logic [5:0]                         tour_city,
    output logic                               finished
);

    ats_pkg::ats_cmd_t cmd;
    ats_pkg::ats_status_t sts;

    ats_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    ats_datapath u_datapath (
        .clk                 (clk),
        .rst_n               (rst_n),
        .cmd                 (cmd),
        .sts                 (sts),
        .cfg_write           (cfg_write),
        .cfg_index           (cfg_index),
        .cfg_data            (cfg_data),
        .operation           (operation),
        .from_city           (from_city),
        .to_city             (to_city),
        .distance_value      (distance_value),
        .first_position      (first_position),
        .second_position     (second_position),
        .uniform_fraction    (uniform_fraction),
        .status              (status),
        .accepted            (accepted),
        .tour_length         (tour_length),
        .current_temperature (current_temperature),
        .tour_city           (tour_city),
        .finished            (finished)
    );

endmodule
